// ===== hdl/ttpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared types and event codes for the two-contact pinch tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ttpt_pkg;

    localparam int TTPT_COORD_BITS = 16;
    localparam int TTPT_OUT_W      = 17;

    localparam logic [4:0] EV_TYPE_SYN      = 5'd0;
    localparam logic [4:0] EV_TYPE_ABS      = 5'd3;
    localparam logic [9:0] EV_CODE_DROPPED  = 10'd3;
    localparam logic [9:0] EV_CODE_SLOT     = 10'h2f;
    localparam logic [9:0] EV_CODE_X        = 10'h35;
    localparam logic [9:0] EV_CODE_Y        = 10'h36;
    localparam logic [9:0] EV_CODE_TRACK    = 10'h39;

    localparam logic [1:0] SLOT_NONE = 2'd2;

    typedef struct packed {
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
    } ttpt_event_t;

    typedef struct packed {
        logic [1:0]            finger_count;
        logic                  pair_valid;
        logic [TTPT_OUT_W-1:0] distance;
        logic [TTPT_OUT_W-1:0] mid_x_doubled;
        logic [TTPT_OUT_W-1:0] mid_y_doubled;
    } ttpt_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ttpt_root_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULX,
        ST_MULY,
        ST_ADD,
        ST_START,
        ST_ROOT,
        ST_OUT
    } ttpt_state_t;

endpackage

`default_nettype wire

// ===== hdl/ttpt_slot_state.sv =====
// ----------------------------------------------------------------------------
// ttpt_slot_state
// Contact slot registers: current slot, down and seen flags, positions.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_slot_state
    import ttpt_pkg::*;
#(
    parameter int COORD_BITS = TTPT_COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  upd,
    input  wire ttpt_event_t           evt,
    output logic [1:0]                 usable,
    output logic [COORD_BITS-1:0]      x0,
    output logic [COORD_BITS-1:0]      x1,
    output logic [COORD_BITS-1:0]      y0,
    output logic [COORD_BITS-1:0]      y1
);

    logic [1:0]            cur_slot_reg, cur_slot_next;
    logic [1:0]            down_reg, down_next;
    logic [1:0]            xseen_reg, xseen_next;
    logic [1:0]            yseen_reg, yseen_next;
    logic [COORD_BITS-1:0] xpos_reg [2];
    logic [COORD_BITS-1:0] ypos_reg [2];
    logic [COORD_BITS-1:0] sat_value;
    logic                  wr_x;
    logic                  wr_y;
    logic                  idx;

    // Negative values clamp to zero, anything above the top code clamps to it.
    always_comb begin
        if (evt.event_value[31]) begin
            sat_value = '0;
        end else if (|evt.event_value[30:COORD_BITS]) begin
            sat_value = '1;
        end else begin
            sat_value = evt.event_value[COORD_BITS-1:0];
        end
    end

    assign idx = cur_slot_reg[0];

    always_comb begin
        cur_slot_next = cur_slot_reg;
        down_next     = down_reg;
        xseen_next    = xseen_reg;
        yseen_next    = yseen_reg;
        wr_x          = 1'b0;
        wr_y          = 1'b0;
        if (upd) begin
            if (evt.event_type == EV_TYPE_SYN) begin
                if (evt.event_code == EV_CODE_DROPPED) begin
                    cur_slot_next = '0;
                    down_next     = '0;
                    xseen_next    = '0;
                    yseen_next    = '0;
                end
            end else if (evt.event_type == EV_TYPE_ABS) begin
                if (evt.event_code == EV_CODE_SLOT) begin
                    if (evt.event_value == 32'sd0) begin
                        cur_slot_next = 2'd0;
                    end else if (evt.event_value == 32'sd1) begin
                        cur_slot_next = 2'd1;
                    end else begin
                        cur_slot_next = SLOT_NONE;
                    end
                end else if (!cur_slot_reg[1]) begin
                    if (evt.event_code == EV_CODE_TRACK) begin
                        down_next[idx]  = !evt.event_value[31];
                        xseen_next[idx] = 1'b0;
                        yseen_next[idx] = 1'b0;
                    end else if (evt.event_code == EV_CODE_X) begin
                        xseen_next[idx] = 1'b1;
                        wr_x            = 1'b1;
                    end else if (evt.event_code == EV_CODE_Y) begin
                        yseen_next[idx] = 1'b1;
                        wr_y            = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_slot_reg <= '0;
            down_reg     <= '0;
            xseen_reg    <= '0;
            yseen_reg    <= '0;
        end else begin
            cur_slot_reg <= cur_slot_next;
            down_reg     <= down_next;
            xseen_reg    <= xseen_next;
            yseen_reg    <= yseen_next;
        end
    end

    // A position only counts after its seen flag is set, so it needs no reset.
    always_ff @(posedge aclk) begin
        if (wr_x) begin
            xpos_reg[idx] <= sat_value;
        end
        if (wr_y) begin
            ypos_reg[idx] <= sat_value;
        end
    end

    assign usable = down_reg & xseen_reg & yseen_reg;
    assign x0     = xpos_reg[0];
    assign x1     = xpos_reg[1];
    assign y0     = ypos_reg[0];
    assign y1     = ypos_reg[1];

endmodule

`default_nettype wire

// ===== hdl/ttpt_isqrt.sv =====
// ----------------------------------------------------------------------------
// ttpt_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_isqrt
    import ttpt_pkg::*;
#(
    parameter int ROOT_BITS = TTPT_COORD_BITS + 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [2*ROOT_BITS-1:0] operand,
    output ttpt_root_stat_t             stat,
    output logic [ROOT_BITS-1:0]        root
);

    localparam int OPW = 2 * ROOT_BITS;
    localparam int RW  = ROOT_BITS + 3;
    localparam int CW  = $clog2(ROOT_BITS + 1);

    logic [OPW-1:0]       op_reg, op_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;

    assign rem_sh = {rem_reg[RW-3:0], op_reg[OPW-1:OPW-2]};
    assign trial  = RW'({root_reg, 2'b01});

    always_comb begin
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(ROOT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            op_next = {op_reg[OPW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

// ===== hdl/two_touch_pinch_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// two_touch_pinch_tracker_unit
// Two-slot multitouch event tracker with pinch distance and midpoint.
// ----------------------------------------------------------------------------
// Every accepted event request updates the two contact slots and yields one
// result with the finger count and, when both contacts are usable, the floor
// distance and the doubled midpoint. The block handles one event at a time.
// An event that leaves fewer than two usable contacts passes from evaluation
// straight to the output state. With both contacts usable, one shared
// multiplier squares dx and then dy, the squares are added, and the square
// root unit produces one root bit per cycle. A finished result waits in the
// output register, so the next event is taken while it has not yet been
// drained.
// ----------------------------------------------------------------------------
`default_nettype none

module two_touch_pinch_tracker_unit
    import ttpt_pkg::*;
#(
    parameter int COORD_BITS = TTPT_COORD_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire ttpt_event_t  s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output ttpt_result_t      m_data
);

    localparam int RB   = COORD_BITS + 1;
    localparam int SUMW = (RB > TTPT_OUT_W) ? RB : TTPT_OUT_W;

    ttpt_state_t           state_reg, state_next;
    logic [1:0]            usable;
    logic [COORD_BITS-1:0] x0, x1, y0, y1;
    logic [COORD_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;
    logic [2*COORD_BITS-1:0] sq_reg, sq_next;
    logic [2*RB-1:0]       acc_reg, acc_next;
    logic [COORD_BITS-1:0] mul_op;
    logic                  root_start;
    logic                  out_load;
    ttpt_root_stat_t       root_stat;
    logic [RB-1:0]         root;
    logic                  accept;
    logic                  pair;
    logic                  m_valid_reg, m_valid_next;
    ttpt_result_t          m_data_reg, m_data_next;
    logic [SUMW-1:0]       mid_x, mid_y, dist_ext;

    assign accept = s_valid && s_ready;
    assign pair   = &usable;

    ttpt_slot_state #(
        .COORD_BITS(COORD_BITS)
    ) u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (accept),
        .evt     (s_data),
        .usable  (usable),
        .x0      (x0),
        .x1      (x1),
        .y0      (y0),
        .y1      (y1)
    );

    ttpt_isqrt #(
        .ROOT_BITS(RB)
    ) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (acc_reg),
        .stat    (root_stat),
        .root    (root)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) begin
                state_next = ST_EVAL;
            end
            ST_EVAL:  state_next = pair ? ST_MULX : ST_OUT;
            ST_MULX:  state_next = ST_MULY;
            ST_MULY:  state_next = ST_ADD;
            ST_ADD:   state_next = ST_START;
            ST_START: state_next = ST_ROOT;
            ST_ROOT:  if (root_stat.done) begin
                state_next = ST_OUT;
            end
            ST_OUT:   if (!m_valid_reg || m_ready) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_ready    = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_START: root_start = 1'b1;
            ST_OUT:   out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    // The one multiplier squares dx first and dy on the following cycle.
    assign mul_op = (state_reg == ST_MULX) ? dx_reg : dy_reg;

    always_comb begin
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        sq_next  = sq_reg;
        acc_next = acc_reg;
        unique case (state_reg)
            ST_EVAL: begin
                dx_next = (x0 > x1) ? x0 - x1 : x1 - x0;
                dy_next = (y0 > y1) ? y0 - y1 : y1 - y0;
            end
            ST_MULX: sq_next = mul_op * mul_op;
            ST_MULY: begin
                acc_next = (2*RB)'(sq_reg);
                sq_next  = mul_op * mul_op;
            end
            ST_ADD:  acc_next = acc_reg + (2*RB)'(sq_reg);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
    end

    assign mid_x    = SUMW'(x0) + SUMW'(x1);
    assign mid_y    = SUMW'(y0) + SUMW'(y1);
    assign dist_ext = SUMW'(root);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next              = 1'b1;
            m_data_next.finger_count  = {1'b0, usable[0]} + {1'b0, usable[1]};
            m_data_next.pair_valid    = pair;
            m_data_next.distance      = pair ? dist_ext[TTPT_OUT_W-1:0] : '0;
            m_data_next.mid_x_doubled = pair ? mid_x[TTPT_OUT_W-1:0] : '0;
            m_data_next.mid_y_doubled = pair ? mid_y[TTPT_OUT_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== bench/two_touch_pinch_tracker_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_touch_pinch_tracker_unit_test
// Self-checking bench for the two-contact pinch tracker.
// ----------------------------------------------------------------------------
// Directed event requests cover slot selection, saturation, lifts, drops and
// ignored events. Random gesture frames with random spacing on both channels
// follow. A behavioral tracker predicts every result, which is compared field
// by field as it leaves the block.
// ----------------------------------------------------------------------------

module two_touch_pinch_tracker_unit_test
    import ttpt_pkg::*;
();

    localparam logic [9:0] SYN_REPORT_CODE = 10'd0;
    localparam int COORD_MAX     = (1 << TTPT_COORD_BITS) - 1;
    localparam int RANDOM_EVENTS = 1000;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    ttpt_event_t  s_data;
    logic         m_valid;
    logic         m_ready;
    ttpt_result_t m_data;

    // Tracker state as the block should hold it.
    logic [1:0]                 trk_slot;
    logic                       trk_down  [2];
    logic                       trk_xseen [2];
    logic                       trk_yseen [2];
    logic [TTPT_COORD_BITS-1:0] trk_x     [2];
    logic [TTPT_COORD_BITS-1:0] trk_y     [2];

    ttpt_result_t pending_results[$];
    int           tx_gap_max;
    int           rx_stall_max;
    int           events_sent;
    int           results_checked;
    int           pair_results;
    int           mismatches;
    int           cycle_count;

    two_touch_pinch_tracker_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void clear_tracker();
        trk_slot = 2'd0;
        for (int i = 0; i < 2; i++) begin
            trk_down[i]  = 1'b0;
            trk_xseen[i] = 1'b0;
            trk_yseen[i] = 1'b0;
            trk_x[i]     = '0;
            trk_y[i]     = '0;
        end
    endfunction

    function automatic logic [TTPT_COORD_BITS-1:0] clamp_coord(logic signed [31:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > COORD_MAX) begin
            return '1;
        end
        return v[TTPT_COORD_BITS-1:0];
    endfunction

    function automatic logic [TTPT_OUT_W-1:0] floor_root(longint unsigned n);
        logic [TTPT_OUT_W-1:0] root;
        longint unsigned       trial;
        root = '0;
        for (int b = TTPT_OUT_W - 1; b >= 0; b--) begin
            trial = longint'(root) | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial[TTPT_OUT_W-1:0];
            end
        end
        return root;
    endfunction

    // Applies one event to the tracker and returns the result it should cause.
    function automatic ttpt_result_t track_event(ttpt_event_t ev);
        ttpt_result_t    res;
        logic            usable_a;
        logic            usable_b;
        logic [1:0]      s;
        longint unsigned dx;
        longint unsigned dy;
        s = trk_slot;
        if (ev.event_type == EV_TYPE_SYN) begin
            if (ev.event_code == EV_CODE_DROPPED) begin
                clear_tracker();
            end
        end else if (ev.event_type == EV_TYPE_ABS) begin
            if (ev.event_code == EV_CODE_SLOT) begin
                trk_slot = (ev.event_value == 0 || ev.event_value == 1) ?
                           ev.event_value[1:0] : SLOT_NONE;
            end else if (s != SLOT_NONE) begin
                case (ev.event_code)
                    EV_CODE_TRACK: begin
                        trk_down[s[0]]  = (ev.event_value >= 0);
                        trk_xseen[s[0]] = 1'b0;
                        trk_yseen[s[0]] = 1'b0;
                    end
                    EV_CODE_X: begin
                        trk_x[s[0]]     = clamp_coord(ev.event_value);
                        trk_xseen[s[0]] = 1'b1;
                    end
                    EV_CODE_Y: begin
                        trk_y[s[0]]     = clamp_coord(ev.event_value);
                        trk_yseen[s[0]] = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        usable_a = trk_down[0] && trk_xseen[0] && trk_yseen[0];
        usable_b = trk_down[1] && trk_xseen[1] && trk_yseen[1];
        res = '0;
        res.finger_count = {1'b0, usable_a} + {1'b0, usable_b};
        res.pair_valid   = usable_a && usable_b;
        if (usable_a && usable_b) begin
            dx = (trk_x[0] > trk_x[1]) ? trk_x[0] - trk_x[1] : trk_x[1] - trk_x[0];
            dy = (trk_y[0] > trk_y[1]) ? trk_y[0] - trk_y[1] : trk_y[1] - trk_y[0];
            res.distance      = floor_root(dx * dx + dy * dy);
            res.mid_x_doubled = {1'b0, trk_x[0]} + {1'b0, trk_x[1]};
            res.mid_y_doubled = {1'b0, trk_y[0]} + {1'b0, trk_y[1]};
        end
        return res;
    endfunction

    function automatic void flag_field(string name, logic [TTPT_OUT_W-1:0] want,
                                       logic [TTPT_OUT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                         name, results_checked, want, got);
            end
        end
    endfunction

    // Predicts at each accepted request and checks each delivered result.
    always @(posedge aclk) begin : check_results
        ttpt_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(track_event(s_data));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result with no request pending: %h", m_data);
                    end
                end else begin
                    want = pending_results.pop_front();
                    flag_field("finger_count", TTPT_OUT_W'(want.finger_count),
                               TTPT_OUT_W'(m_data.finger_count));
                    flag_field("pair_valid", TTPT_OUT_W'(want.pair_valid),
                               TTPT_OUT_W'(m_data.pair_valid));
                    flag_field("distance", want.distance, m_data.distance);
                    flag_field("mid_x_doubled", want.mid_x_doubled, m_data.mid_x_doubled);
                    flag_field("mid_y_doubled", want.mid_y_doubled, m_data.mid_y_doubled);
                    if (want.pair_valid) begin
                        pair_results++;
                    end
                end
                results_checked++;
            end
        end
    end

    initial begin : drain_results
        int stall;
        m_ready <= 1'b0;
        forever begin
            stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic send_event(input ttpt_event_t ev);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
    endtask

    task automatic send_abs(input logic [9:0] code, input logic signed [31:0] value);
        ttpt_event_t ev;
        ev.event_type  = EV_TYPE_ABS;
        ev.event_code  = code;
        ev.event_value = value;
        send_event(ev);
    endtask

    task automatic send_other(input logic [4:0] kind, input logic [9:0] code,
                              input logic signed [31:0] value);
        ttpt_event_t ev;
        ev.event_type  = kind;
        ev.event_code  = code;
        ev.event_value = value;
        send_event(ev);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_pair_geometry();
        send_abs(EV_CODE_SLOT, 0);
        send_abs(EV_CODE_TRACK, 10);
        send_abs(EV_CODE_X, 100);
        send_abs(EV_CODE_Y, 200);
        send_abs(EV_CODE_SLOT, 1);
        send_abs(EV_CODE_TRACK, 11);
        send_abs(EV_CODE_X, 400);
        send_abs(EV_CODE_Y, 600);
    endtask

    // Coordinates clamp at both ends, giving the longest possible distance.
    task automatic test_coordinate_saturation();
        send_abs(EV_CODE_X, 32'sh7fffffff);
        send_abs(EV_CODE_Y, 32'sh80000000);
        send_abs(EV_CODE_SLOT, 0);
        send_abs(EV_CODE_X, -1);
        send_abs(EV_CODE_Y, COORD_MAX + 1);
    endtask

    task automatic test_slot_out_of_range();
        send_abs(EV_CODE_SLOT, 2);
        send_abs(EV_CODE_X, 7);
        send_abs(EV_CODE_SLOT, -1);
        send_abs(EV_CODE_TRACK, -1);
    endtask

    task automatic test_ignored_events();
        send_other(5'd31, EV_CODE_X, 32'sh12345678);
        send_abs(EV_CODE_DROPPED, 0);
        send_other(EV_TYPE_SYN, EV_CODE_SLOT, 1);
    endtask

    task automatic test_lift_and_drop();
        send_abs(EV_CODE_SLOT, 1);
        send_abs(EV_CODE_TRACK, -1);
        send_other(EV_TYPE_SYN, EV_CODE_DROPPED, 0);
        send_abs(EV_CODE_X, 5);
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 0;
            2: return COORD_MAX;
            3: return -$signed($urandom_range(1, 1000));
            4: return COORD_MAX + $urandom_range(1, 1000);
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    // Mostly well-formed slot/track/X/Y frames closed by a report, plus noise.
    task automatic send_gesture_frame();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            send_other(EV_TYPE_SYN, EV_CODE_DROPPED, $urandom);
        end else if (kind < 3) begin
            send_other(5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)), $urandom);
        end else begin
            send_abs(EV_CODE_SLOT, ($urandom_range(0, 15) == 0) ? $urandom
                                                                : $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0: send_abs(EV_CODE_TRACK, -$signed($urandom_range(1, 100)));
                    1: send_abs(EV_CODE_TRACK, $urandom);
                    default: send_abs(EV_CODE_TRACK, $urandom_range(0, 65535));
                endcase
            end
            if ($urandom_range(0, 4) != 0) begin
                send_abs(EV_CODE_X, pick_coord());
            end
            if ($urandom_range(0, 4) != 0) begin
                send_abs(EV_CODE_Y, pick_coord());
            end
            send_other(EV_TYPE_SYN, SYN_REPORT_CODE, $urandom_range(0, 3));
        end
    endtask

    task automatic test_random_gestures();
        int  start;
        int  phase;
        bit  paused;
        start  = events_sent;
        phase  = -1;
        paused = 1'b0;
        while (events_sent - start < RANDOM_EVENTS) begin
            if ((events_sent - start) / 100 != phase) begin
                phase = (events_sent - start) / 100;
                case ($urandom_range(0, 3))
                    0: begin tx_gap_max = 12; rx_stall_max = 12; end
                    1: begin tx_gap_max = 0;  rx_stall_max = 0;  end
                    2: begin tx_gap_max = 12; rx_stall_max = 0;  end
                    default: begin tx_gap_max = 0; rx_stall_max = 12; end
                endcase
            end
            if (!paused && events_sent - start >= RANDOM_EVENTS / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
            send_gesture_frame();
        end
    endtask

    initial begin : run_tests
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_data          <= '0;
        tx_gap_max      = 12;
        rx_stall_max    = 12;
        events_sent     = 0;
        results_checked = 0;
        pair_results    = 0;
        mismatches      = 0;
        cycle_count     = 0;
        clear_tracker();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pair_geometry();
        test_coordinate_saturation();
        test_slot_out_of_range();
        test_ignored_events();
        test_lift_and_drop();
        test_random_gestures();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d touch events, checked %0d results, %0d with two usable contacts.",
                 events_sent, results_checked, pair_results);
        $display("Mismatches: %0d, results still pending: %0d.",
                 mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
